// ----- rtl/core/ccf_pkg.sv -----
package ccf_pkg;

  localparam int KERNEL_SIZE     = 5;
  localparam int CROSS_SIZE      = 3;
  localparam int MAX_WIDTH       = 1024;
  localparam int COEFF_FRAC_BITS = 12;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_MAIN  = 2'd1,
    OP_CROSS = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_ZERO  = 2'd1,
    REG_GAIN  = 2'd2,
    REG_NONE  = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_MUL,
    ST_DONE
  } state_t;

  // Per-step control for the multiply-accumulate unit
  typedef struct packed {
    logic               clear;
    logic               step;
    logic               centre;
    logic signed [15:0] k;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic        [7:0]  zero;
  } mac_ctl_t;

endpackage

// ----- rtl/core/ccf_in_if.sv -----
interface ccf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic               start_of_frame;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [6:0]         coeff_index;
  logic signed [15:0] coeff_value;

  modport source(output valid, op, start_of_frame, red, green, blue, coeff_index,
                 coeff_value, input ready);
  modport sink(input valid, op, start_of_frame, red, green, blue, coeff_index,
               coeff_value, output ready);
endinterface

// ----- rtl/core/ccf_out_if.sv -----
interface ccf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [9:0]  out_x;
  logic [11:0] out_y;

  modport source(output valid, out_red, out_green, out_blue, out_x, out_y, input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_x, out_y, output ready);
endinterface

// ----- rtl/core/ccf_cell.sv -----
module ccf_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [23:0] din,
  output logic [23:0] dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

// ----- rtl/core/ccf_mac.sv -----
module ccf_mac #(
  parameter int MW = 32,
  parameter int XW = 32,
  parameter int F  = ccf_pkg::COEFF_FRAC_BITS
) (
  input  logic                 clk,
  input  ccf_pkg::mac_ctl_t    ctl,
  input  logic [23:0]          pix,
  output logic signed [MW-1:0] m_acc [3],
  output logic signed [XW-1:0] x_acc [3]
);

  logic signed [8:0]    d   [3];
  logic signed [24:0]   pk  [3];
  logic signed [24:0]   pl  [3];
  logic signed [24:0]   ph  [3];
  logic signed [MW-1:0] cen [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d[c] = $signed({1'b0, pix[23-8*c -: 8]}) - $signed({1'b0, ctl.zero});
    end
    for (int c = 0; c < 3; c++) begin
      pk[c]  = d[c] * ctl.k;
      // lower weight on the next channel, higher on the one after
      pl[c]  = d[(c+1)%3] * ctl.lo;
      ph[c]  = d[(c+2)%3] * ctl.hi;
      cen[c] = ctl.centre ? (MW'(d[c]) <<< F) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctl.clear) begin
        m_acc[c] <= '0;
        x_acc[c] <= '0;
      end else if (ctl.step) begin
        m_acc[c] <= m_acc[c] + MW'(pk[c]) + cen[c];
        x_acc[c] <= x_acc[c] + XW'(pl[c]) + XW'(ph[c]);
      end
    end
  end

endmodule

// ----- rtl/core/cross_color_convolution_filter.sv -----
// Interior pixel: window read from the line store into the cell chain (ST_LOAD),
// rotated through the MAC unit (ST_CALC), gain scaled (ST_MUL), then registered
// as the result beat (ST_DONE). A new input beat is accepted only in ST_IDLE,
// once the previous result is in the output register, so a stalled output holds
// off input; border pixels and coefficient writes are accepted and give no beat.
// Reset (rst, synchronous) restores position, coefficients, registers, handshake.
module cross_color_convolution_filter #(
  parameter int KERNEL_SIZE     = ccf_pkg::KERNEL_SIZE,
  parameter int CROSS_SIZE      = ccf_pkg::CROSS_SIZE,
  parameter int MAX_WIDTH       = ccf_pkg::MAX_WIDTH,
  parameter int COEFF_FRAC_BITS = ccf_pkg::COEFF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  ccf_in_if.sink                     pix_in,
  ccf_out_if.source                  pix_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int F      = COEFF_FRAC_BITS;
  localparam int K_LO   = KERNEL_SIZE / 2;
  localparam int C_LO   = CROSS_SIZE / 2;
  localparam int K_HI   = KERNEL_SIZE - 1 - K_LO;
  localparam int C_HI   = CROSS_SIZE - 1 - C_LO;
  localparam int LO     = (K_LO > C_LO) ? K_LO : C_LO;
  localparam int HI     = (K_HI > C_HI) ? K_HI : C_HI;
  localparam int WIN    = LO + HI + 1;
  localparam int NCELL  = WIN * WIN;
  localparam int NMAIN  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int NCROSS = CROSS_SIZE * CROSS_SIZE;
  localparam int KOFF   = LO - K_LO;
  localparam int COFF   = LO - C_LO;
  localparam int SW     = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int NW     = $clog2(NCELL + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (WW > 11) ? WW : 11;
  localparam int XOW    = (CW > 10) ? CW : 10;
  localparam int AW     = $clog2(WIN * MAX_WIDTH);
  localparam int MW     = 9 + 16 + $clog2(NMAIN + 1) + 1;
  localparam int XW     = 9 + 16 + 2 + $clog2(NCROSS + 1);
  localparam int TW     = ((MW + F > XW + 16) ? MW + F : XW + 16) + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB)
  // ---------------------------------------------------------------------------
  logic [10:0]        image_width;
  logic [7:0]         zero_level;
  logic signed [15:0] cross_gain;
  logic               cfg_wr;
  ccf_pkg::reg_t      cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = ccf_pkg::reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd640;
      zero_level  <= 8'd128;
      cross_gain  <= 16'sd4096;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        ccf_pkg::REG_WIDTH: image_width <= pwdata[10:0];
        ccf_pkg::REG_ZERO:  zero_level  <= pwdata[7:0];
        ccf_pkg::REG_GAIN:  cross_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      ccf_pkg::REG_WIDTH: prdata = {21'd0, image_width};
      ccf_pkg::REG_ZERO:  prdata = {24'd0, zero_level};
      ccf_pkg::REG_GAIN:  prdata = {{16{cross_gain[15]}}, cross_gain};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Coefficient stores, written by op beats
  // ---------------------------------------------------------------------------
  logic signed [15:0] main_coeffs  [NMAIN];
  logic signed [15:0] cross_coeffs [2*NCROSS];

  ccf_pkg::state_t st, st_next;
  logic            in_acc, pix_acc;

  assign in_acc  = pix_in.valid && pix_in.ready;
  assign pix_acc = in_acc && (pix_in.op == ccf_pkg::OP_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NMAIN; i++) main_coeffs[i] <= '0;
      for (int i = 0; i < 2*NCROSS; i++) cross_coeffs[i] <= '0;
    end else if (in_acc) begin
      // indexes past the store fall through every compare and are dropped
      for (int i = 0; i < NMAIN; i++) begin
        if (pix_in.op == ccf_pkg::OP_MAIN && pix_in.coeff_index == 7'(i)) begin
          main_coeffs[i] <= pix_in.coeff_value;
        end
      end
      for (int i = 0; i < 2*NCROSS; i++) begin
        if (pix_in.op == ccf_pkg::OP_CROSS && pix_in.coeff_index == 7'(i)) begin
          cross_coeffs[i] <= pix_in.coeff_value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position for the incoming pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt, col_b, cx_n, cx_q;
  logic [11:0]   row_cnt, row_b, cy_q;
  logic [SW-1:0] line_slot, slot_b, slot_inc;
  logic [EW-1:0] wd;
  logic [WW-1:0] wid;
  logic          last, interior;
  logic [AW-1:0] wr_addr;

  always_comb begin
    // clamp the width into 1..MAX_WIDTH
    wd = EW'(image_width);
    if (wd > EW'(MAX_WIDTH)) begin
      wd = EW'(MAX_WIDTH);
    end else if (wd == '0) begin
      wd = EW'(1);
    end
    wid = WW'(wd);

    col_b  = pix_in.start_of_frame ? '0 : col_cnt;
    row_b  = pix_in.start_of_frame ? '0 : row_cnt;
    slot_b = pix_in.start_of_frame ? '0 : line_slot;

    // width lowered mid-line: take the pixel as the last column
    cx_n     = (WW'(col_b) >= wid) ? CW'(wid - WW'(1)) : col_b;
    last     = (WW'(cx_n) == wid - WW'(1));
    interior = (cx_n >= CW'(WIN - 1)) && (row_b >= 12'(WIN - 1));
    slot_inc = (slot_b == SW'(WIN - 1)) ? '0 : slot_b + SW'(1);
    wr_addr  = AW'(slot_b) * AW'(MAX_WIDTH) + AW'(cx_n);
  end

  // ---------------------------------------------------------------------------
  // Line store: one write at acceptance, then one registered read per cycle
  // ---------------------------------------------------------------------------
  logic [23:0]   line_mem [WIN*MAX_WIDTH];
  logic [23:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rwx, rwy, rslot;
  logic [NW-1:0] is_cnt, cnt;
  logic          rd_vld;

  assign rd_addr = AW'(rslot) * AW'(MAX_WIDTH)
                 + AW'(CW'(cx_q + CW'(rwx) - CW'(WIN - 1)));

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      line_mem[wr_addr] <= {pix_in.red, pix_in.green, pix_in.blue};
    end
    rd_data <= line_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Cell chain: window pixels shift in from the top end, then rotate past
  // cell 0, which feeds the MAC unit
  // ---------------------------------------------------------------------------
  logic [23:0] cell_q [NCELL];
  logic [23:0] chain_in;
  logic        shift;

  assign chain_in = (st == ccf_pkg::ST_CALC) ? cell_q[0] : rd_data;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == NCELL - 1) begin : g_top
      ccf_cell u_cell (.clk(clk), .shift(shift), .din(chain_in), .dout(cell_q[i]));
    end else begin : g_mid
      ccf_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[i+1]), .dout(cell_q[i]));
    end
  end

  // ---------------------------------------------------------------------------
  // Tap decode for the window position at the head of the chain
  // ---------------------------------------------------------------------------
  logic [SW-1:0]     cwx, cwy;
  ccf_pkg::mac_ctl_t ctl;
  logic              out_vld, out_load;

  assign out_load = (st == ccf_pkg::ST_DONE) && (!out_vld || pix_out.ready);

  always_comb begin
    st_next    = st;
    shift      = 1'b0;
    ctl        = '0;
    ctl.zero   = zero_level;
    unique case (st)
      ccf_pkg::ST_IDLE: begin
        if (pix_acc && interior) st_next = ccf_pkg::ST_LOAD;
      end
      ccf_pkg::ST_LOAD: begin
        shift     = rd_vld;
        ctl.clear = 1'b1;
        if (rd_vld && cnt == NW'(NCELL - 1)) st_next = ccf_pkg::ST_CALC;
      end
      ccf_pkg::ST_CALC: begin
        shift      = 1'b1;
        ctl.step   = 1'b1;
        ctl.centre = (cwx == SW'(LO)) && (cwy == SW'(LO));
        for (int my = 0; my < KERNEL_SIZE; my++) begin
          for (int mx = 0; mx < KERNEL_SIZE; mx++) begin
            if (cwy == SW'(my + KOFF) && cwx == SW'(mx + KOFF)) begin
              ctl.k = main_coeffs[my*KERNEL_SIZE + mx];
            end
          end
        end
        for (int my = 0; my < CROSS_SIZE; my++) begin
          for (int mx = 0; mx < CROSS_SIZE; mx++) begin
            if (cwy == SW'(my + COFF) && cwx == SW'(mx + COFF)) begin
              ctl.lo = cross_coeffs[2*(my*CROSS_SIZE + mx)];
              ctl.hi = cross_coeffs[2*(my*CROSS_SIZE + mx) + 1];
            end
          end
        end
        if (cnt == NW'(NCELL - 1)) st_next = ccf_pkg::ST_MUL;
      end
      ccf_pkg::ST_MUL: begin
        st_next = ccf_pkg::ST_DONE;
      end
      ccf_pkg::ST_DONE: begin
        if (out_load) st_next = ccf_pkg::ST_IDLE;
      end
      default: st_next = ccf_pkg::ST_IDLE;
    endcase
  end

  assign pix_in.ready = (st == ccf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ccf_pkg::ST_IDLE;
      col_cnt   <= '0;
      row_cnt   <= '0;
      line_slot <= '0;
      rd_vld    <= 1'b0;
      is_cnt    <= '0;
      cnt       <= '0;
      rwx       <= '0;
      rwy       <= '0;
      rslot     <= '0;
      cwx       <= '0;
      cwy       <= '0;
    end else begin
      st     <= st_next;
      rd_vld <= (st == ccf_pkg::ST_LOAD) && (is_cnt < NW'(NCELL));
      if (pix_acc) begin
        // advance the raster position; wrap the line slot at the line end
        col_cnt   <= last ? '0 : cx_n + CW'(1);
        row_cnt   <= last ? row_b + 12'd1 : row_b;
        line_slot <= last ? slot_inc : slot_b;
        rslot     <= slot_inc;
        rwx       <= '0;
        rwy       <= '0;
        cwx       <= '0;
        cwy       <= '0;
        is_cnt    <= '0;
        cnt       <= '0;
      end
      if (st == ccf_pkg::ST_LOAD) begin
        if (is_cnt < NW'(NCELL)) begin
          is_cnt <= is_cnt + NW'(1);
          if (rwx == SW'(WIN - 1)) begin
            rwx   <= '0;
            rwy   <= rwy + SW'(1);
            rslot <= (rslot == SW'(WIN - 1)) ? '0 : rslot + SW'(1);
          end else begin
            rwx <= rwx + SW'(1);
          end
        end
        if (rd_vld) begin
          cnt <= (cnt == NW'(NCELL - 1)) ? '0 : cnt + NW'(1);
        end
      end
      if (st == ccf_pkg::ST_CALC) begin
        cnt <= cnt + NW'(1);
        if (cwx == SW'(WIN - 1)) begin
          cwx <= '0;
          cwy <= cwy + SW'(1);
        end else begin
          cwx <= cwx + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      cx_q <= cx_n;
      cy_q <= row_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate, scale the cross sum by the gain, clamp and floor
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0]    m_acc [3];
  logic signed [XW-1:0]    x_acc [3];
  logic signed [XW+15:0]   xg    [3];
  logic signed [TW-1:0]    tot   [3];
  logic signed [TW-1:0]    sh    [3];
  logic        [7:0]       q     [3];
  logic signed [8:0]       zl_s;

  ccf_mac #(.MW(MW), .XW(XW), .F(F)) u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .pix  (cell_q[0]),
    .m_acc(m_acc),
    .x_acc(x_acc)
  );

  always_ff @(posedge clk) begin
    if (st == ccf_pkg::ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        xg[c] <= x_acc[c] * cross_gain;
      end
    end
  end

  assign zl_s = $signed({1'b0, zero_level});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = (TW'(m_acc[c]) <<< F) + TW'(xg[c]) + (TW'(zl_s) <<< (2*F));
      sh[c]  = tot[c] >>> (2*F);
      if (tot[c][TW-1]) begin
        q[c] = 8'd0;
      end else if (sh[c] > TW'(255)) begin
        q[c] = 8'd255;
      end else begin
        q[c] = sh[c][7:0];
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (pix_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix_out.out_red   <= q[0];
      pix_out.out_green <= q[1];
      pix_out.out_blue  <= q[2];
      pix_out.out_x     <= 10'(XOW'(cx_q) - XOW'(HI));
      pix_out.out_y     <= cy_q - 12'(HI);
    end
  end

  assign pix_out.valid = out_vld;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(st == ccf_pkg::ST_DONE))
    else $error("result beat raised outside the done state");

  a_load_interior: assert property (@(posedge clk) disable iff (rst)
    (st == ccf_pkg::ST_LOAD) |-> (cx_q >= CW'(WIN - 1) && cy_q >= 12'(WIN - 1)))
    else $error("window load started for a border position");

  a_calc_length: assert property (@(posedge clk) disable iff (rst)
    $rose(st == ccf_pkg::ST_MUL) |-> $past(cnt == NW'(NCELL - 1)))
    else $error("accumulation ended before every window cell was seen");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// Cross-color convolution filter testbench.
// A behavioral predictor tracks line history, coefficients and registers,
// and computes every interior output pixel when its input beat is accepted.
// A scoreboard process compares each output beat, field by field, with the
// oldest predicted pixel. Named tests run in turn: coefficient loading,
// small directed frames at register extremes, width limits, back pressure,
// and random frames under several idle/stall mixes.
module tb;

  localparam int LAT = 60;  // settle time used by drain(); longer than the result latency

  typedef struct {
    ccf_pkg::op_t       op;
    bit                 sof;
    bit [7:0]           red;
    bit [7:0]           green;
    bit [7:0]           blue;
    bit [6:0]           idx;
    logic signed [15:0] val;
  } pix_item_t;

  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [9:0]  x;
    bit [11:0] y;
  } filt_pix_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ccf_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ccf_in_if  pix_in();
  ccf_out_if pix_out();

  cross_color_convolution_filter dut (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: line history, coefficients, shadow registers, position
  bit [23:0] line_hist[5][1024];
  longint    main_taps[25];
  longint    cross_taps[18];
  int        cfg_width;
  int        cfg_zero;
  longint    cfg_gain;
  int        col_pos;
  int        row_pos;
  int        line_slot;

  filt_pix_t expected_pix[$];
  int        errors;
  int        sent_items;
  int        idle_pct;
  int        stall_pct;
  int        hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit [23:0] win_pixel(int cx, int dx, int dy);
    return line_hist[(line_slot + 3 + dy) % 5][cx - 2 + dx];
  endfunction

  function automatic longint chan(bit [23:0] p, int c);
    return longint'(p[23 - 8 * c -: 8]) - cfg_zero;
  endfunction

  // Advance the predictor by one accepted beat; queue any output pixel
  task automatic predict_pixel(pix_item_t it);
    int        w, cx, cy, c, mx, my, t;
    longint    acc[3];
    longint    k, lo, hi, v, r, g, b;
    bit [23:0] p;
    filt_pix_t res;
    if (it.op == ccf_pkg::OP_MAIN) begin
      if (it.idx < 25) main_taps[it.idx] = it.val;
      return;
    end
    if (it.op == ccf_pkg::OP_CROSS) begin
      if ((it.idx >> 1) < 9) cross_taps[it.idx] = it.val;
      return;
    end
    if (it.op != ccf_pkg::OP_PIXEL) return;
    w = (cfg_width > 1024) ? 1024 : cfg_width;
    if (w == 0) w = 1;
    if (it.sof) begin
      col_pos = 0;
      row_pos = 0;
      line_slot = 0;
    end
    if (col_pos >= w) col_pos = w - 1;
    cx = col_pos;
    cy = row_pos;
    line_hist[line_slot][cx] = {it.red, it.green, it.blue};
    if (cx >= 4 && cy >= 4) begin
      p = win_pixel(cx, 0, 0);
      for (c = 0; c < 3; c++) acc[c] = chan(p, c) * 64'sd16777216;
      for (my = 0; my < 5; my++)
        for (mx = 0; mx < 5; mx++) begin
          k = main_taps[my * 5 + mx] * 4096;
          p = win_pixel(cx, mx - 2, my - 2);
          for (c = 0; c < 3; c++) acc[c] += chan(p, c) * k;
        end
      for (my = 0; my < 3; my++)
        for (mx = 0; mx < 3; mx++) begin
          t = my * 3 + mx;
          lo = cross_taps[2 * t] * cfg_gain;
          hi = cross_taps[2 * t + 1] * cfg_gain;
          p = win_pixel(cx, mx - 1, my - 1);
          r = chan(p, 0);
          g = chan(p, 1);
          b = chan(p, 2);
          acc[0] += g * lo + b * hi;
          acc[1] += b * lo + r * hi;
          acc[2] += r * lo + g * hi;
        end
      for (c = 0; c < 3; c++) begin
        v = acc[c] + longint'(cfg_zero) * 64'sd16777216;
        if (v < 0) v = 0;
        else begin
          v = v >>> 24;
          if (v > 255) v = 255;
        end
        acc[c] = v;
      end
      res.red = acc[0][7:0];
      res.green = acc[1][7:0];
      res.blue = acc[2][7:0];
      res.x = 10'(cx - 2);
      res.y = 12'(cy - 2);
      expected_pix.push_back(res);
    end
    if (cx + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 12'hFFF;
      line_slot = (line_slot + 1) % 5;
    end else begin
      col_pos = cx + 1;
    end
  endtask

  // Send one beat: optional idle gap, then hold until accepted
  task automatic send_item(pix_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      pix_in.valid = 1'b0;
      @(negedge clk);
    end
    pix_in.valid = 1'b1;
    pix_in.op = it.op;
    pix_in.start_of_frame = it.sof;
    pix_in.red = it.red;
    pix_in.green = it.green;
    pix_in.blue = it.blue;
    pix_in.coeff_index = it.idx;
    pix_in.coeff_value = it.val;
    do @(posedge clk); while (!pix_in.ready);
    predict_pixel(it);
    sent_items++;
    @(negedge clk);
    pix_in.valid = 1'b0;
  endtask

  task automatic send_pixel(bit sof, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pix_item_t it;
    it.op = ccf_pkg::OP_PIXEL;
    it.sof = sof;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.idx = 7'($urandom);
    it.val = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_coeff(ccf_pkg::op_t op, bit [6:0] idx, logic signed [15:0] val);
    pix_item_t it;
    it.op = op;
    it.sof = 1'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    it.idx = idx;
    it.val = val;
    send_item(it);
  endtask

  function automatic logic signed [15:0] rand_coeff();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(1023)) - 512);
  endfunction

  // Wait for every predicted pixel, then let the block settle
  task automatic drain();
    pix_in.valid = 1'b0;
    wait (expected_pix.size() == 0);
    repeat (LAT) @(negedge clk);
  endtask

  // Register write: setup then access phase; only while idle
  task automatic reg_write(ccf_pkg::reg_t idx, bit [31:0] value);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ccf_pkg::ADDR_W'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      ccf_pkg::REG_WIDTH: cfg_width = value[10:0];
      ccf_pkg::REG_ZERO:  cfg_zero = value[7:0];
      ccf_pkg::REG_GAIN:  cfg_gain = longint'($signed(value[15:0]));
      default: ;
    endcase
  endtask

  // One frame of random pixels; coefficient writes and unused ops mixed in
  task automatic random_frame(int w, int rows, bit broken);
    int n, i;
    n = w * rows;
    if (broken) n = $urandom_range(1, n);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0)
        send_coeff(ccf_pkg::OP_MAIN, 7'($urandom_range(26)), rand_coeff());
      if ($urandom_range(29) == 0)
        send_coeff(ccf_pkg::OP_CROSS, 7'($urandom_range(19)), rand_coeff());
      if ($urandom_range(59) == 0)
        send_coeff(ccf_pkg::OP_NONE, 7'($urandom), 16'($urandom));
      send_pixel(i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Coefficient loading: extremes, last valid taps, out-of-range indexes
  task automatic test_coeff_load();
    send_coeff(ccf_pkg::OP_MAIN, 7'd0, 16'sh7FFF);
    send_coeff(ccf_pkg::OP_MAIN, 7'd24, -16'sh8000);
    send_coeff(ccf_pkg::OP_MAIN, 7'd12, 16'sd4096);
    send_coeff(ccf_pkg::OP_MAIN, 7'd25, 16'sd1000);
    send_coeff(ccf_pkg::OP_MAIN, 7'd127, 16'sd1000);
    send_coeff(ccf_pkg::OP_CROSS, 7'd0, -16'sh8000);
    send_coeff(ccf_pkg::OP_CROSS, 7'd17, 16'sh7FFF);
    send_coeff(ccf_pkg::OP_CROSS, 7'd18, 16'sd1000);
    send_coeff(ccf_pkg::OP_NONE, 7'h7F, 16'shFFFF);
  endtask

  // 5x5 frames with one interior centre, at register extremes
  task automatic test_directed_frames();
    int i, pass;
    reg_write(ccf_pkg::REG_WIDTH, 32'd5);
    for (pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          reg_write(ccf_pkg::REG_ZERO, 32'd0);
          reg_write(ccf_pkg::REG_GAIN, 32'h8000);
        end
        1: begin
          reg_write(ccf_pkg::REG_ZERO, 32'd255);
          reg_write(ccf_pkg::REG_GAIN, 32'h7FFF);
        end
        default: begin
          reg_write(ccf_pkg::REG_ZERO, 32'd128);
          reg_write(ccf_pkg::REG_GAIN, 32'd0);
        end
      endcase
      for (i = 0; i < 25; i++)
        send_pixel(i == 0, (i % 2) ? 8'hFF : 8'h00, 8'(i * 10), (i % 3) ? 8'h00 : 8'hFF);
    end
    // zero the kernel: output must equal the centre pixel
    for (i = 0; i < 25; i++) send_coeff(ccf_pkg::OP_MAIN, 7'(i), 16'sd0);
    for (i = 0; i < 25; i++) send_pixel(i == 0, 8'(i * 9), 8'hFF - 8'(i), 8'(i));
  endtask

  // Width zero acts as one column; width above the maximum acts as the maximum
  task automatic test_width_limits();
    int i;
    reg_write(ccf_pkg::REG_WIDTH, 32'd0);
    for (i = 0; i < 8; i++) send_pixel(i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
    reg_write(ccf_pkg::REG_WIDTH, 32'd2047);
    reg_write(ccf_pkg::REG_GAIN, 32'd4096);
    for (i = 0; i < 40; i++) send_pixel(i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full pause
  task automatic test_back_pressure();
    reg_write(ccf_pkg::REG_WIDTH, 32'd16);
    hold_off = 3000;
    random_frame(16, 8, 1'b0);
    drain();
  endtask

  task automatic test_random_frames(int idle, int stall, int quota);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: reg_write(ccf_pkg::REG_ZERO,
                       $urandom_range(1) ? 32'($urandom_range(255)) : 32'd0);
          1: reg_write(ccf_pkg::REG_GAIN,
                       $urandom_range(3) ? 32'($urandom_range(8192)) : $urandom);
          2: reg_write(ccf_pkg::REG_ZERO, 32'd255);
          default: reg_write(ccf_pkg::REG_WIDTH, 32'($urandom_range(8, 24)));
        endcase
      end
      random_frame(cfg_width, $urandom_range(5, 7), $urandom_range(9) == 0);
    end
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      pix_out.ready = 1'b0;
    end else if (hold_off > 0) begin
      pix_out.ready = 1'b0;
      hold_off--;
    end else begin
      pix_out.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: compare each output beat with the oldest predicted pixel
  always @(posedge clk) begin
    filt_pix_t e;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_pix.size() == 0) begin
        $display("%0t: unexpected beat r=%0d g=%0d b=%0d x=%0d y=%0d", $time,
                 pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                 pix_out.out_x, pix_out.out_y);
        errors++;
      end else begin
        e = expected_pix.pop_front();
        if (pix_out.out_red !== e.red || pix_out.out_green !== e.green ||
            pix_out.out_blue !== e.blue || pix_out.out_x !== e.x ||
            pix_out.out_y !== e.y) begin
          $display("%0t: mismatch exp r=%0d g=%0d b=%0d x=%0d y=%0d", $time,
                   e.red, e.green, e.blue, e.x, e.y);
          $display("%0t:          got r=%0d g=%0d b=%0d x=%0d y=%0d", $time,
                   pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                   pix_out.out_x, pix_out.out_y);
          errors++;
        end
      end
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_in.valid = 1'b0;
    pix_in.op = ccf_pkg::OP_PIXEL;
    pix_in.start_of_frame = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    pix_in.coeff_index = '0;
    pix_in.coeff_value = '0;
    pix_out.ready = 1'b0;
    for (i = 0; i < 25; i++) main_taps[i] = 0;
    for (i = 0; i < 18; i++) cross_taps[i] = 0;
    cfg_width = 640;
    cfg_zero = 128;
    cfg_gain = 4096;
    col_pos = 0;
    row_pos = 0;
    line_slot = 0;
    errors = 0;
    sent_items = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_coeff_load();
    test_directed_frames();
    test_width_limits();
    test_back_pressure();
    test_random_frames(0, 0, 200);
    test_random_frames(87, 0, 350);
    test_random_frames(0, 87, 350);
    test_random_frames(18, 18, 350);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
